[design/tpp_pkg.sv]
// ----------------------------------------------------------------------------
// tpp_pkg
// Shared types and character constants for the tagged text packet parser.
// ----------------------------------------------------------------------------
package tpp_pkg;

    localparam logic [7:0] CHAR_NUL   = 8'h00;
    localparam logic [7:0] CHAR_SPACE = 8'h20;
    localparam logic [7:0] CHAR_MINUS = 8'h2D;
    localparam logic [7:0] CHAR_COLON = 8'h3A;
    localparam logic [7:0] CHAR_ZERO  = 8'h30;
    localparam logic [7:0] CHAR_NINE  = 8'h39;
    localparam logic [7:0] CHAR_UA    = 8'h41;
    localparam logic [7:0] CHAR_UD    = 8'h44;
    localparam logic [7:0] CHAR_UF    = 8'h46;
    localparam logic [7:0] CHAR_LA    = 8'h61;
    localparam logic [7:0] CHAR_LB    = 8'h62;
    localparam logic [7:0] CHAR_LD    = 8'h64;
    localparam logic [7:0] CHAR_LF    = 8'h66;
    localparam logic [7:0] CHAR_LH    = 8'h68;
    localparam logic [7:0] CHAR_LK    = 8'h6B;
    localparam logic [7:0] CHAR_LN    = 8'h6E;
    localparam logic [7:0] CHAR_LP    = 8'h70;
    localparam logic [7:0] CHAR_LV    = 8'h76;
    localparam logic [7:0] CHAR_LW    = 8'h77;
    localparam logic [7:0] CHAR_LX    = 8'h78;
    localparam logic [7:0] CHAR_LY    = 8'h79;

    // Integer field slots, in output order.
    localparam int unsigned NUM_FIELDS = 8;
    localparam logic [2:0] FLD_VERSION = 3'd0;
    localparam logic [2:0] FLD_WIDTH   = 3'd1;
    localparam logic [2:0] FLD_HEIGHT  = 3'd2;
    localparam logic [2:0] FLD_POS_X   = 3'd3;
    localparam logic [2:0] FLD_POS_Y   = 3'd4;
    localparam logic [2:0] FLD_BUTTON  = 3'd5;
    localparam logic [2:0] FLD_PRESS   = 3'd6;
    localparam logic [2:0] FLD_KEY     = 3'd7;

    typedef struct packed {
        logic       is_zero;
        logic       is_ctrl;
        logic       is_digit;
        logic       is_hex;
        logic [3:0] nibble;
        logic       is_int_tag;
        logic [2:0] int_idx;
        logic       is_str_tag;
        logic       is_drop_tag;
        logic       is_x;
        logic       is_minus;
        logic       is_colon;
    } byte_class_t;

    typedef struct packed {
        logic [7:0]  kind;
        logic [31:0] version;
        logic [31:0] width;
        logic [31:0] height;
        logic [31:0] pos_x;
        logic [31:0] pos_y;
        logic [31:0] button;
        logic [31:0] press;
        logic [15:0] key;
        logic        stopped;
    } result_t;

endpackage

[design/tagged_text_packet_parser.sv]
// ----------------------------------------------------------------------------
// tagged_text_packet_parser
// Byte-stream parser for zero-terminated tagged text packets.
// ----------------------------------------------------------------------------
// The s_ channel carries one received byte per beat (s_rx_byte). Each packet
// is a kind byte, then tag letters with integer or string arguments, then a
// zero byte. The m_ channel delivers one beat per closed non-empty packet
// with the kind, the seven integer fields, the low 16 bits of the key code
// and a flag that is set when an unknown tag cut decoding short.
// Throughput is one byte per cycle while the result register is free or
// being drained: an accepted byte sits in the input register while the
// classifier and the parse state logic update the state, and a closing
// zero byte loads the result register, which drives m_.
// If the receiver stalls, the result register holds its beat; the parser
// keeps consuming bytes only while the result register is free or being
// drained, and s_ready drops once the input register holds a byte it
// cannot process. Synchronous reset (aresetn low) empties both registers
// and returns the parser to waiting for a kind byte, with all fields zero.
// ----------------------------------------------------------------------------
module tagged_text_packet_parser (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_valid,
    output logic               s_ready,
    input  logic [7:0]         s_rx_byte,
    output logic               m_valid,
    input  logic               m_ready,
    output logic [7:0]         m_packet_kind,
    output logic signed [31:0] m_version_value,
    output logic signed [31:0] m_width_value,
    output logic signed [31:0] m_height_value,
    output logic signed [31:0] m_pos_x,
    output logic signed [31:0] m_pos_y,
    output logic signed [31:0] m_button_value,
    output logic signed [31:0] m_press_value,
    output logic [15:0]        m_key_code,
    output logic               m_stopped_early
);

    logic             in_valid_reg;
    logic [7:0]       in_byte_reg;
    logic             out_valid_reg;
    tpp_pkg::result_t out_reg;
    tpp_pkg::result_t core_result;
    logic             core_finish;
    logic             proceed;

    assign proceed = in_valid_reg && (!out_valid_reg || m_ready);
    assign s_ready = !in_valid_reg || proceed;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_valid && s_ready) begin
            in_valid_reg <= 1'b1;
        end else if (proceed) begin
            in_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            in_byte_reg <= s_rx_byte;
        end
    end

    tpp_parse_core u_core (
        .aclk    (aclk),
        .aresetn (aresetn),
        .byte_en (proceed),
        .rx_byte (in_byte_reg),
        .finish  (core_finish),
        .result  (core_result)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (proceed && core_finish) begin
            out_valid_reg <= 1'b1;
        end else if (m_ready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (proceed && core_finish) begin
            out_reg <= core_result;
        end
    end

    assign m_valid         = out_valid_reg;
    assign m_packet_kind   = out_reg.kind;
    assign m_version_value = signed'(out_reg.version);
    assign m_width_value   = signed'(out_reg.width);
    assign m_height_value  = signed'(out_reg.height);
    assign m_pos_x         = signed'(out_reg.pos_x);
    assign m_pos_y         = signed'(out_reg.pos_y);
    assign m_button_value  = signed'(out_reg.button);
    assign m_press_value   = signed'(out_reg.press);
    assign m_key_code      = out_reg.key;
    assign m_stopped_early = out_reg.stopped;

`ifndef NO_ASSERTIONS
    // A held byte stays put until the parser consumes it.
    a_hold_input: assert property (@(posedge aclk) disable iff (!aresetn)
        in_valid_reg && !proceed |=> in_valid_reg && $stable(in_byte_reg))
        else $error("input byte changed before it was consumed");

    // Only a zero byte can close a packet.
    a_finish_on_nul: assert property (@(posedge aclk) disable iff (!aresetn)
        proceed && core_finish |-> in_byte_reg == tpp_pkg::CHAR_NUL)
        else $error("packet closed on a nonzero byte");

    // An emitted packet always carries a real kind byte.
    a_kind_nonzero: assert property (@(posedge aclk) disable iff (!aresetn)
        proceed && core_finish |=> m_valid && m_packet_kind != 8'd0)
        else $error("result emitted without a kind byte");

    // Backpressure only when a byte is waiting in the input register.
    a_ready_low: assert property (@(posedge aclk) disable iff (!aresetn)
        !s_ready |-> in_valid_reg && out_valid_reg && !m_ready)
        else $error("s_ready low without a stalled byte");
`endif

endmodule

[design/tpp_byte_class.sv]
// ----------------------------------------------------------------------------
// tpp_byte_class
// Classifies one received byte: terminator, digit, hex digit, tag kinds.
// ----------------------------------------------------------------------------
module tpp_byte_class (
    input  logic [7:0]          rx_byte,
    output tpp_pkg::byte_class_t cls
);

    logic is_dec;
    logic is_lhex;
    logic is_uhex;

    assign is_dec  = (rx_byte >= tpp_pkg::CHAR_ZERO) && (rx_byte <= tpp_pkg::CHAR_NINE);
    assign is_lhex = (rx_byte >= tpp_pkg::CHAR_LA) && (rx_byte <= tpp_pkg::CHAR_LF);
    assign is_uhex = (rx_byte >= tpp_pkg::CHAR_UA) && (rx_byte <= tpp_pkg::CHAR_UF);

    always_comb begin
        cls          = '0;
        cls.is_zero  = (rx_byte == tpp_pkg::CHAR_NUL);
        cls.is_ctrl  = (rx_byte < tpp_pkg::CHAR_SPACE);
        cls.is_digit = is_dec;
        cls.is_hex   = is_dec || is_lhex || is_uhex;
        // Letters a-f and A-F share the low nibble pattern 1..6, so add nine.
        cls.nibble   = is_dec ? rx_byte[3:0] : 4'(rx_byte[3:0] + 4'd9);
        cls.is_x     = (rx_byte == tpp_pkg::CHAR_LX);
        cls.is_minus = (rx_byte == tpp_pkg::CHAR_MINUS);
        cls.is_colon = (rx_byte == tpp_pkg::CHAR_COLON);
        cls.is_str_tag  = (rx_byte == tpp_pkg::CHAR_LP) || (rx_byte == tpp_pkg::CHAR_LN) ||
                          (rx_byte == tpp_pkg::CHAR_UF);
        cls.is_drop_tag = (rx_byte == tpp_pkg::CHAR_UD);
        case (rx_byte)
            tpp_pkg::CHAR_LV: begin
                cls.is_int_tag = 1'b1;
                cls.int_idx    = tpp_pkg::FLD_VERSION;
            end
            tpp_pkg::CHAR_LW: begin
                cls.is_int_tag = 1'b1;
                cls.int_idx    = tpp_pkg::FLD_WIDTH;
            end
            tpp_pkg::CHAR_LH: begin
                cls.is_int_tag = 1'b1;
                cls.int_idx    = tpp_pkg::FLD_HEIGHT;
            end
            tpp_pkg::CHAR_LX: begin
                cls.is_int_tag = 1'b1;
                cls.int_idx    = tpp_pkg::FLD_POS_X;
            end
            tpp_pkg::CHAR_LY: begin
                cls.is_int_tag = 1'b1;
                cls.int_idx    = tpp_pkg::FLD_POS_Y;
            end
            tpp_pkg::CHAR_LB: begin
                cls.is_int_tag = 1'b1;
                cls.int_idx    = tpp_pkg::FLD_BUTTON;
            end
            tpp_pkg::CHAR_LD: begin
                cls.is_int_tag = 1'b1;
                cls.int_idx    = tpp_pkg::FLD_PRESS;
            end
            tpp_pkg::CHAR_LK: begin
                cls.is_int_tag = 1'b1;
                cls.int_idx    = tpp_pkg::FLD_KEY;
            end
            default: begin
                cls.is_int_tag = 1'b0;
                cls.int_idx    = tpp_pkg::FLD_VERSION;
            end
        endcase
    end

endmodule

[design/tpp_parse_core.sv]
// ----------------------------------------------------------------------------
// tpp_parse_core
// Parse state machine and field registers; consumes one byte per enable.
// ----------------------------------------------------------------------------
module tpp_parse_core (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             byte_en,
    input  logic [7:0]       rx_byte,
    output logic             finish,
    output tpp_pkg::result_t result
);

    typedef enum logic [7:0] {
        PH_KIND_RAW  = 8'b0000_0001,
        PH_KIND_SKIP = 8'b0000_0010,
        PH_TAG       = 8'b0000_0100,
        PH_INT_FIRST = 8'b0000_1000,
        PH_HEX       = 8'b0001_0000,
        PH_DEC       = 8'b0010_0000,
        PH_STR       = 8'b0100_0000,
        PH_DROP      = 8'b1000_0000
    } phase_t;

    tpp_pkg::byte_class_t cls;

    phase_t      phase_reg, phase_next;
    logic [2:0]  sel_reg, sel_next;
    logic [31:0] acc_reg, acc_next;
    logic        neg_reg, neg_next;
    logic [31:0] field_reg  [tpp_pkg::NUM_FIELDS];
    logic [31:0] field_next [tpp_pkg::NUM_FIELDS];
    logic [7:0]  kind_reg, kind_next;
    logic        stop_reg, stop_next;

    logic        do_tag;
    logic        store_en;
    logic [31:0] acc_dec;
    logic [31:0] acc_hex;
    logic [31:0] store_val;

    tpp_byte_class u_class (
        .rx_byte (rx_byte),
        .cls     (cls)
    );

    assign acc_dec   = 32'((acc_reg << 3) + (acc_reg << 1) + {28'd0, cls.nibble});
    assign acc_hex   = {acc_reg[27:0], cls.nibble};
    assign store_val = neg_reg ? 32'(32'd0 - acc_next) : acc_next;

    always_comb begin
        phase_next = phase_reg;
        sel_next   = sel_reg;
        acc_next   = acc_reg;
        neg_next   = neg_reg;
        kind_next  = kind_reg;
        stop_next  = stop_reg;
        field_next = field_reg;
        finish     = 1'b0;
        do_tag     = 1'b0;
        store_en   = 1'b0;

        case (phase_reg)
            PH_KIND_RAW, PH_KIND_SKIP: begin
                if (cls.is_zero) begin
                    phase_next = PH_KIND_SKIP;
                end else if (!(phase_reg == PH_KIND_SKIP && cls.is_ctrl)) begin
                    kind_next  = rx_byte;
                    stop_next  = 1'b0;
                    acc_next   = '0;
                    neg_next   = 1'b0;
                    sel_next   = '0;
                    phase_next = PH_TAG;
                    for (int i = 0; i < tpp_pkg::NUM_FIELDS; i++) begin
                        field_next[i] = '0;
                    end
                end
            end
            PH_TAG: begin
                do_tag = 1'b1;
            end
            PH_INT_FIRST: begin
                if (cls.is_x) begin
                    phase_next = PH_HEX;
                end else if (cls.is_minus) begin
                    neg_next   = 1'b1;
                    phase_next = PH_DEC;
                end else if (cls.is_digit) begin
                    acc_next   = {28'd0, cls.nibble};
                    store_en   = 1'b1;
                    phase_next = PH_DEC;
                end else begin
                    do_tag = 1'b1;
                end
            end
            PH_HEX: begin
                if (cls.is_hex) begin
                    acc_next = acc_hex;
                    store_en = 1'b1;
                end else begin
                    do_tag = 1'b1;
                end
            end
            PH_DEC: begin
                if (cls.is_digit) begin
                    acc_next = acc_dec;
                    store_en = 1'b1;
                end else begin
                    do_tag = 1'b1;
                end
            end
            PH_STR: begin
                if (cls.is_zero) begin
                    finish = 1'b1;
                end else if (cls.is_colon) begin
                    phase_next = PH_TAG;
                end
            end
            PH_DROP: begin
                if (cls.is_zero) begin
                    finish = 1'b1;
                end
            end
            default: begin
                phase_next = PH_KIND_SKIP;
            end
        endcase

        if (store_en) begin
            field_next[sel_reg] = store_val;
        end

        // A byte that ends an integer is reinterpreted as the next tag.
        if (do_tag) begin
            if (cls.is_zero) begin
                finish = 1'b1;
            end else if (cls.is_int_tag) begin
                sel_next                 = cls.int_idx;
                acc_next                 = '0;
                neg_next                 = 1'b0;
                field_next[cls.int_idx]  = '0;
                phase_next               = PH_INT_FIRST;
            end else if (cls.is_str_tag) begin
                phase_next = PH_STR;
            end else if (cls.is_drop_tag) begin
                phase_next = PH_DROP;
            end else begin
                stop_next  = 1'b1;
                phase_next = PH_DROP;
            end
        end

        if (finish) begin
            phase_next = PH_KIND_SKIP;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg <= PH_KIND_RAW;
            sel_reg   <= '0;
            acc_reg   <= '0;
            neg_reg   <= 1'b0;
            kind_reg  <= '0;
            stop_reg  <= 1'b0;
            for (int i = 0; i < tpp_pkg::NUM_FIELDS; i++) begin
                field_reg[i] <= '0;
            end
        end else if (byte_en) begin
            phase_reg <= phase_next;
            sel_reg   <= sel_next;
            acc_reg   <= acc_next;
            neg_reg   <= neg_next;
            kind_reg  <= kind_next;
            stop_reg  <= stop_next;
            field_reg <= field_next;
        end
    end

    always_comb begin
        result.kind    = kind_reg;
        result.version = field_reg[tpp_pkg::FLD_VERSION];
        result.width   = field_reg[tpp_pkg::FLD_WIDTH];
        result.height  = field_reg[tpp_pkg::FLD_HEIGHT];
        result.pos_x   = field_reg[tpp_pkg::FLD_POS_X];
        result.pos_y   = field_reg[tpp_pkg::FLD_POS_Y];
        result.button  = field_reg[tpp_pkg::FLD_BUTTON];
        result.press   = field_reg[tpp_pkg::FLD_PRESS];
        result.key     = field_reg[tpp_pkg::FLD_KEY][15:0];
        result.stopped = stop_reg;
    end

endmodule

[tb/tb.sv]
// ----------------------------------------------------------------------------
// tb
// Self-checking testbench for tagged_text_packet_parser. A byte-level
// predictor tracks the parse of the incoming stream and queues one expected
// result per closed packet; each m_ beat is compared field by field with the
// oldest queued result. Stimulus is a short directed stream followed by
// random packets, noise and broken tags, with random gaps and stalls on both
// channels and one long receiver hold-off.
// ----------------------------------------------------------------------------
module tb;

    import tpp_pkg::*;

    typedef enum logic [2:0] {
        PH_KIND_RAW,
        PH_KIND_SKIP,
        PH_TAG,
        PH_INT_FIRST,
        PH_HEX,
        PH_DEC,
        PH_STR,
        PH_DROP
    } parse_phase_t;

    class packet_scoreboard;
        parse_phase_t phase;
        logic [2:0]   sel;
        logic [31:0]  acc;
        logic         neg;
        logic [31:0]  vals [NUM_FIELDS];
        logic [7:0]   kind;
        logic         stop;
        result_t      expected_packets [$];
        int           errors;
        int           produced;
        int           checked;

        function new();
            phase = PH_KIND_RAW;
            sel = '0;
            acc = '0;
            neg = 1'b0;
            foreach (vals[i]) vals[i] = '0;
            kind = '0;
            stop = 1'b0;
            errors = 0;
            produced = 0;
            checked = 0;
        endfunction

        function int nibble_of(logic [7:0] b);
            if (b >= CHAR_ZERO && b <= CHAR_NINE) return b - CHAR_ZERO;
            if (b >= CHAR_LA && b <= CHAR_LF) return b - CHAR_LA + 10;
            if (b >= CHAR_UA && b <= CHAR_UF) return b - CHAR_UA + 10;
            return -1;
        endfunction

        function void store_value();
            vals[sel] = neg ? (32'd0 - acc) : acc;
        endfunction

        function void close_packet();
            result_t r;
            r.kind    = kind;
            r.version = vals[FLD_VERSION];
            r.width   = vals[FLD_WIDTH];
            r.height  = vals[FLD_HEIGHT];
            r.pos_x   = vals[FLD_POS_X];
            r.pos_y   = vals[FLD_POS_Y];
            r.button  = vals[FLD_BUTTON];
            r.press   = vals[FLD_PRESS];
            r.key     = vals[FLD_KEY][15:0];
            r.stopped = stop;
            expected_packets.push_back(r);
            produced++;
            phase = PH_KIND_SKIP;
        endfunction

        function void start_int(logic [2:0] idx);
            sel = idx;
            acc = '0;
            neg = 1'b0;
            vals[idx] = '0;
            phase = PH_INT_FIRST;
        endfunction

        function void take_tag(logic [7:0] b);
            case (b)
                CHAR_NUL: close_packet();
                CHAR_LV:  start_int(FLD_VERSION);
                CHAR_LW:  start_int(FLD_WIDTH);
                CHAR_LH:  start_int(FLD_HEIGHT);
                CHAR_LX:  start_int(FLD_POS_X);
                CHAR_LY:  start_int(FLD_POS_Y);
                CHAR_LB:  start_int(FLD_BUTTON);
                CHAR_LD:  start_int(FLD_PRESS);
                CHAR_LK:  start_int(FLD_KEY);
                CHAR_LP, CHAR_LN, CHAR_UF: phase = PH_STR;
                CHAR_UD:  phase = PH_DROP;
                default: begin
                    stop = 1'b1;
                    phase = PH_DROP;
                end
            endcase
        endfunction

        // Advance the parse by one accepted input beat.
        function void note_byte(logic [7:0] b);
            int hv;
            hv = nibble_of(b);
            case (phase)
                PH_KIND_RAW, PH_KIND_SKIP: begin
                    if (b == CHAR_NUL) begin
                        phase = PH_KIND_SKIP;
                    end else if (!(phase == PH_KIND_SKIP && b < CHAR_SPACE)) begin
                        kind = b;
                        foreach (vals[i]) vals[i] = '0;
                        stop = 1'b0;
                        acc = '0;
                        neg = 1'b0;
                        sel = '0;
                        phase = PH_TAG;
                    end
                end
                PH_TAG: take_tag(b);
                PH_INT_FIRST: begin
                    if (b == CHAR_LX) begin
                        phase = PH_HEX;
                    end else if (b == CHAR_MINUS) begin
                        neg = 1'b1;
                        phase = PH_DEC;
                    end else if (b >= CHAR_ZERO && b <= CHAR_NINE) begin
                        acc = 32'(b - CHAR_ZERO);
                        store_value();
                        phase = PH_DEC;
                    end else begin
                        take_tag(b);
                    end
                end
                PH_HEX: begin
                    if (hv >= 0) begin
                        acc = (acc << 4) | 32'(hv);
                        store_value();
                    end else begin
                        take_tag(b);
                    end
                end
                PH_DEC: begin
                    if (b >= CHAR_ZERO && b <= CHAR_NINE) begin
                        acc = acc * 32'd10 + 32'(b - CHAR_ZERO);
                        store_value();
                    end else begin
                        take_tag(b);
                    end
                end
                PH_STR: begin
                    if (b == CHAR_NUL) close_packet();
                    else if (b == CHAR_COLON) phase = PH_TAG;
                end
                PH_DROP: begin
                    if (b == CHAR_NUL) close_packet();
                end
                default: phase = PH_KIND_SKIP;
            endcase
        endfunction

        function void cmp_field(string name, logic [31:0] exp_v, logic [31:0] act_v);
            if (exp_v !== act_v) begin
                $error("%s: expected %h, got %h", name, exp_v, act_v);
                errors++;
            end
        endfunction

        function void check_result(result_t got);
            result_t exp_r;
            if (expected_packets.size() == 0) begin
                $error("result beat with no packet pending, kind %h", got.kind);
                errors++;
                return;
            end
            exp_r = expected_packets.pop_front();
            checked++;
            cmp_field("packet_kind", 32'(exp_r.kind), 32'(got.kind));
            cmp_field("version_value", exp_r.version, got.version);
            cmp_field("width_value", exp_r.width, got.width);
            cmp_field("height_value", exp_r.height, got.height);
            cmp_field("pos_x", exp_r.pos_x, got.pos_x);
            cmp_field("pos_y", exp_r.pos_y, got.pos_y);
            cmp_field("button_value", exp_r.button, got.button);
            cmp_field("press_value", exp_r.press, got.press);
            cmp_field("key_code", 32'(exp_r.key), 32'(got.key));
            cmp_field("stopped_early", 32'(exp_r.stopped), 32'(got.stopped));
        endfunction
    endclass

    logic               aclk;
    logic               aresetn = 1'b0;
    logic               s_valid = 1'b0;
    logic               s_ready;
    logic [7:0]         s_rx_byte = 8'h00;
    logic               m_valid;
    logic               m_ready = 1'b0;
    logic [7:0]         m_packet_kind;
    logic signed [31:0] m_version_value;
    logic signed [31:0] m_width_value;
    logic signed [31:0] m_height_value;
    logic signed [31:0] m_pos_x;
    logic signed [31:0] m_pos_y;
    logic signed [31:0] m_button_value;
    logic signed [31:0] m_press_value;
    logic [15:0]        m_key_code;
    logic               m_stopped_early;

    packet_scoreboard sb;
    logic [7:0]       tx_bytes [$];
    int               useful_bytes = 0;

    tagged_text_packet_parser dut (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .s_valid         (s_valid),
        .s_ready         (s_ready),
        .s_rx_byte       (s_rx_byte),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_packet_kind   (m_packet_kind),
        .m_version_value (m_version_value),
        .m_width_value   (m_width_value),
        .m_height_value  (m_height_value),
        .m_pos_x         (m_pos_x),
        .m_pos_y         (m_pos_y),
        .m_button_value  (m_button_value),
        .m_press_value   (m_press_value),
        .m_key_code      (m_key_code),
        .m_stopped_early (m_stopped_early)
    );

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    function automatic int gap_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55) return 0;
        if (r < 85) return $urandom_range(1, 3);
        if (r < 97) return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    function automatic void put(logic [7:0] b);
        tx_bytes.push_back(b);
        useful_bytes++;
    endfunction

    function automatic void put_dec(int n);
        repeat (n) put(8'(CHAR_ZERO + $urandom_range(0, 9)));
    endfunction

    function automatic void put_hex(int n);
        int v;
        repeat (n) begin
            v = $urandom_range(0, 15);
            if (v < 10) put(8'(CHAR_ZERO + v));
            else if ($urandom_range(0, 1) == 1) put(8'(CHAR_LA + v - 10));
            else put(8'(CHAR_UA + v - 10));
        end
    endfunction

    function automatic logic [7:0] pick_int_tag();
        case ($urandom_range(0, 7))
            0: return CHAR_LV;
            1: return CHAR_LW;
            2: return CHAR_LH;
            3: return CHAR_LX;
            4: return CHAR_LY;
            5: return CHAR_LB;
            6: return CHAR_LD;
            default: return CHAR_LK;
        endcase
    endfunction

    function automatic void add_number();
        string s;
        case ($urandom_range(0, 9))
            0, 1, 2: put_dec($urandom_range(0, 10));
            3: put_dec($urandom_range(11, 14));
            4, 5: begin
                put(CHAR_LX);
                put_hex($urandom_range(0, 9));
            end
            6, 7: begin
                put(CHAR_MINUS);
                put_dec($urandom_range(0, 11));
            end
            8: begin
                // Values at the edges of the 32-bit range.
                case ($urandom_range(0, 4))
                    0: s = "4294967295";
                    1: s = "-2147483648";
                    2: s = "x80000000";
                    3: s = "xffffffff";
                    default: s = "2147483647";
                endcase
                for (int i = 0; i < s.len(); i++) put(8'(s[i]));
            end
            default: ;
        endcase
    endfunction

    function automatic void add_packet();
        int         r;
        logic [7:0] b;
        r = $urandom_range(0, 99);
        if (r < 8) begin
            repeat ($urandom_range(1, 8)) tx_bytes.push_back(8'($urandom_range(0, 255)));
        end else begin
            if (r < 14) tx_bytes.push_back(8'($urandom_range(1, 31)));
            put(8'($urandom_range(32, 255)));
            repeat ($urandom_range(0, 6)) begin
                r = $urandom_range(0, 99);
                if (r < 62) begin
                    put(pick_int_tag());
                    add_number();
                end else if (r < 77) begin
                    case ($urandom_range(0, 2))
                        0: put(CHAR_LP);
                        1: put(CHAR_LN);
                        default: put(CHAR_UF);
                    endcase
                    repeat ($urandom_range(0, 6)) begin
                        do b = 8'($urandom_range(1, 255)); while (b == CHAR_COLON);
                        put(b);
                    end
                    if ($urandom_range(0, 3) != 0) put(CHAR_COLON);
                end else if (r < 84) begin
                    put(CHAR_UD);
                    repeat ($urandom_range(0, 5)) tx_bytes.push_back(8'($urandom_range(1, 255)));
                end else if (r < 90) begin
                    do b = 8'($urandom_range(1, 255));
                    while (b inside {CHAR_LV, CHAR_LW, CHAR_LH, CHAR_LX, CHAR_LY, CHAR_LB,
                                     CHAR_LD, CHAR_LK, CHAR_LP, CHAR_LN, CHAR_UF, CHAR_UD});
                    put(b);
                    repeat ($urandom_range(0, 5)) tx_bytes.push_back(8'($urandom_range(1, 255)));
                end else begin
                    tx_bytes.push_back(8'($urandom_range(0, 255)));
                end
            end
            put(CHAR_NUL);
            // An occasional empty packet.
            if ($urandom_range(0, 9) == 0) tx_bytes.push_back(CHAR_NUL);
        end
    endfunction

    task automatic send_byte(input logic [7:0] b, input int g);
        if (g > 0) begin
            s_valid <= 1'b0;
            repeat (g) @(posedge aclk);
        end
        s_valid   <= 1'b1;
        s_rx_byte <= b;
        do @(posedge aclk); while (!s_ready);
        sb.note_byte(b);
    endtask

    task automatic send_queued(input bit quiet);
        while (tx_bytes.size() > 0) send_byte(tx_bytes.pop_front(), quiet ? 0 : gap_len());
    endtask

    // Result channel monitor.
    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready) begin
            sb.check_result(result_t'({m_packet_kind, m_version_value, m_width_value,
                                       m_height_value, m_pos_x, m_pos_y, m_button_value,
                                       m_press_value, m_key_code, m_stopped_early}));
        end
    end

    // Receiver: random stalls, ready stretches, and one long hold-off while the
    // sender keeps offering beats.
    initial begin
        bit held;
        int g;
        held = 1'b0;
        @(posedge aclk);
        while (sb == null || !aresetn) @(posedge aclk);
        forever begin
            if (!held && sb.checked >= 6) begin
                m_ready <= 1'b0;
                for (int n = 0; n < 400; n++) @(posedge aclk);
                held = 1'b1;
            end
            if ($urandom_range(0, 99) < 12) begin
                m_ready <= 1'b1;
                repeat ($urandom_range(50, 200)) @(posedge aclk);
            end else begin
                g = gap_len();
                if (g > 0) begin
                    m_ready <= 1'b0;
                    repeat (g) @(posedge aclk);
                end
                m_ready <= 1'b1;
                repeat ($urandom_range(1, 4)) @(posedge aclk);
            end
        end
    end

    initial begin
        sb = new();
        repeat (12) @(posedge aclk);
        aresetn <= 1'b1;

        // A control byte taken as kind right after reset, a hex key that is
        // cut to 16 bits, an empty packet, a skipped control byte, a negative
        // value, a minus after hex that stops decoding, a string ended by a
        // colon, a repeated tag without digits and a string ended by the zero.
        tx_bytes = '{8'h01, CHAR_LK, CHAR_LX, CHAR_UF, CHAR_LF, CHAR_UA, CHAR_NINE, 8'h65,
                     CHAR_NUL,
                     CHAR_NUL, 8'h1F, 8'hFF, CHAR_LW, CHAR_MINUS, CHAR_NINE, CHAR_LY, CHAR_LX,
                     8'(CHAR_ZERO + 1), CHAR_MINUS, CHAR_LV, CHAR_NUL,
                     8'h50, CHAR_LP, CHAR_LA, CHAR_COLON, CHAR_LV, 8'(CHAR_ZERO + 7), CHAR_LV,
                     CHAR_UF, CHAR_LN, CHAR_NUL};
        send_queued(1'b0);

        useful_bytes = 0;
        while (useful_bytes < 650) begin
            add_packet();
            send_queued($urandom_range(0, 3) == 0);
        end
        s_valid <= 1'b0;

        while (sb.expected_packets.size() > 0) @(posedge aclk);
        repeat (20) @(posedge aclk);
        if (sb.errors == 0) begin
            $display("tagged_text_packet_parser regression: pass");
        end else begin
            $display("tagged_text_packet_parser regression: fail");
        end
        $finish;
    end

    initial begin
        #10000000;
        $display("tagged_text_packet_parser regression: fail");
        $finish;
    end

endmodule

[tagged_text_packet_parser.f]
design/tpp_pkg.sv
design/tpp_byte_class.sv
design/tpp_parse_core.sv
design/tagged_text_packet_parser.sv
tb/tb.sv
